### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: invariant violated");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");
// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/swer_pkg.sv
// ----------------------------------------------------------------------------
// swer_pkg
// Shared widths, ring depth, window reset value and status type of the event window counter.
// ----------------------------------------------------------------------------
package swer_pkg;

	// Timestamp and window width in ticks
	localparam int TIME_W = 48;
	// Width of the reported event count and its saturation value
	localparam int COUNT_OUT_W = 11;
	localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = '1;
	// Default ring depth
	localparam int DEPTH_DEFAULT = 1024;
	// Window length after reset: one second of nanosecond ticks
	localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd1000000000;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

endpackage

### design/swer_if.sv
// ----------------------------------------------------------------------------
// swer_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface swer_evt_if;
	logic                         valid;
	logic                         ready;
	logic [swer_pkg::TIME_W-1:0]  event_time;

	modport source (output valid, output event_time, input ready);
	modport sink   (input valid, input event_time, output ready);
endinterface

interface swer_res_if;
	logic                             valid;
	logic                             ready;
	logic [swer_pkg::TIME_W-1:0]      delta_time;
	logic [swer_pkg::COUNT_OUT_W-1:0] events_in_window;

	modport source (output valid, output delta_time, output events_in_window, input ready);
	modport sink   (input valid, input delta_time, input events_in_window, output ready);
endinterface

### design/swer_ring_mem.sv
// ----------------------------------------------------------------------------
// swer_ring_mem
// Timestamp ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swer_ring_mem #(
	parameter int DEPTH = swer_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [swer_pkg::TIME_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [swer_pkg::TIME_W-1:0] rdata
);

	logic [swer_pkg::TIME_W-1:0] mem [DEPTH];

	// Write the pushed timestamp
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; hold data when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/swer_ctrl.sv
// ----------------------------------------------------------------------------
// swer_ctrl
// Event sequencer: pushes the timestamp, then pops expired ring entries one
// per cycle through the memory read port.
// ----------------------------------------------------------------------------
module swer_ctrl #(
	parameter int DEPTH = swer_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [swer_pkg::TIME_W-1:0]      window_ticks,
	input  logic                             start,
	input  logic [swer_pkg::TIME_W-1:0]      event_time,
	input  logic                             out_free,
	output swer_pkg::stat_t                  stat,
	output logic [swer_pkg::TIME_W-1:0]      delta_time,
	output logic [swer_pkg::COUNT_OUT_W-1:0] events_in_window,
	output logic [CNT_W-1:0]                 held_count,
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_waddr,
	output logic [swer_pkg::TIME_W-1:0]      mem_wdata,
	output logic                             mem_re,
	output logic [AW-1:0]                    mem_raddr,
	input  logic [swer_pkg::TIME_W-1:0]      mem_rdata
);

	localparam int CMP_W = (CNT_W > swer_pkg::COUNT_OUT_W) ? CNT_W : swer_pkg::COUNT_OUT_W;

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t                      state_q;
	logic [AW-1:0]               head_q;
	logic [AW-1:0]               tail_q;
	logic [CNT_W-1:0]            count_q;
	logic [swer_pkg::TIME_W-1:0] prev_q;
	logic                        seen_q;
	logic [swer_pkg::TIME_W-1:0] delta_q;
	logic [swer_pkg::TIME_W-1:0] limit_q;
	logic                        limit_ok_q;

	logic                        full;
	logic [AW-1:0]               head_push;
	logic [AW-1:0]               head_inc;
	logic [CNT_W-1:0]            count_push;
	logic [swer_pkg::TIME_W-1:0] delta_new;
	logic                        pop;
	logic                        finish;
	logic [CMP_W-1:0]            count_ext;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	// Push side: drop the oldest entry first when the ring is full
	assign full       = (count_q >= CNT_W'(DEPTH));
	assign head_push  = full ? next_slot(head_q) : head_q;
	assign count_push = full ? count_q : count_q + CNT_W'(1);
	assign delta_new  = (seen_q && (event_time >= prev_q)) ? event_time - prev_q : '0;

	// Scan side: pop while more than one entry remains and the head entry is older than the window start
	assign head_inc = next_slot(head_q);
	assign pop      = (state_q == ST_SCAN) && limit_ok_q && (count_q > CNT_W'(1))
	                  && (mem_rdata < limit_q);
	assign finish   = (state_q == ST_SCAN) && !pop && out_free;

	// Memory port: write on accept, read the next head on accept or pop
	always_comb begin
		mem_we    = start;
		mem_waddr = tail_q;
		mem_wdata = event_time;
		mem_re    = start || pop;
		mem_raddr = start ? head_push : head_inc;
	end

	// Sequencer state and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			prev_q  <= '0;
			seen_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						head_q     <= head_push;
						tail_q     <= next_slot(tail_q);
						count_q    <= count_push;
						prev_q     <= event_time;
						seen_q     <= 1'b1;
						delta_q    <= delta_new;
						limit_ok_q <= (event_time >= window_ticks);
						limit_q    <= event_time - window_ticks;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pop) begin
						head_q  <= head_inc;
						count_q <= count_q - CNT_W'(1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Saturate the count to the result field
	assign count_ext = CMP_W'(count_q);
	assign events_in_window = (count_ext > CMP_W'(swer_pkg::COUNT_MAX)) ? swer_pkg::COUNT_MAX
	                          : count_ext[swer_pkg::COUNT_OUT_W-1:0];

	assign delta_time = delta_q;
	assign held_count = count_q;
	assign stat.busy  = (state_q != ST_IDLE);
	assign stat.done  = finish;

endmodule

### design/sliding_window_event_rate.sv
// ----------------------------------------------------------------------------
// sliding_window_event_rate
// Counts timestamped events inside a sliding time window.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one event word: its timestamp in ticks, non-decreasing.
//   res returns one result word per event: ticks since the previous event
//   (zero for the first after reset or after a backwards step) and the events
//   in the window ending at this event, this one included, capped at the ring depth and at COUNT_MAX.
//   cfg_we/cfg_data write the window length; write only while idle.
// Timing:
//   An event is pushed into the ring memory in its accept cycle, together
//   with the read of the oldest entry. Each further cycle compares one entry
//   and pops it if expired; the ring memory read port sets this pace. The
//   result appears in the output register in the cycle after the scan ends.
//   A new event is accepted only once the scan of the previous one has ended.
// Reset and stalls:
//   Reset empties the ring and restores a one-second (ns) window. The next
//   event may be accepted while a result waits in the output register; a
//   scan that ends while that register is still full holds until res is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_event_rate #(
	parameter int DEPTH = swer_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [swer_pkg::TIME_W-1:0] cfg_data,
	swer_evt_if.sink                    evt,
	swer_res_if.source                  res
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [swer_pkg::TIME_W-1:0]      window_q;
	logic                             start;
	logic                             out_free;
	swer_pkg::stat_t                  stat;
	logic [swer_pkg::TIME_W-1:0]      delta_time;
	logic [swer_pkg::COUNT_OUT_W-1:0] events_in_window;
	logic [CNT_W-1:0]                 held_count;
	logic                             mem_we;
	logic [AW-1:0]                    mem_waddr;
	logic [swer_pkg::TIME_W-1:0]      mem_wdata;
	logic                             mem_re;
	logic [AW-1:0]                    mem_raddr;
	logic [swer_pkg::TIME_W-1:0]      mem_rdata;
	logic                             res_valid_q;
	logic [swer_pkg::TIME_W-1:0]      res_delta_q;
	logic [swer_pkg::COUNT_OUT_W-1:0] res_count_q;

	// Hold the window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swer_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_data;
		end
	end

	// Accept one event word at a time
	assign evt.ready = !stat.busy;
	assign start     = evt.valid && evt.ready;
	assign out_free  = !res_valid_q || res.ready;

	swer_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_ticks     (window_q),
		.start            (start),
		.event_time       (evt.event_time),
		.out_free         (out_free),
		.stat             (stat),
		.delta_time       (delta_time),
		.events_in_window (events_in_window),
		.held_count       (held_count),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_re           (mem_re),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata)
	);

	swer_ring_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.done) begin
			res_valid_q <= 1'b1;
			res_delta_q <= delta_time;
			res_count_q <= events_in_window;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.delta_time       = res_delta_q;
	assign res.events_in_window = res_count_q;

	// Ring occupancy never exceeds its depth
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, held_count <= CNT_W'(DEPTH))
	// An accepted event starts a scan in the next cycle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, evt.valid && evt.ready, stat.busy)
	// A scan always has at least the current event stored
	`ASSERT_IMPLY(a_busy_nonempty, clk, arst_n, stat.busy, held_count != '0)
	// A fresh result always counts the current event
	`ASSERT_IMPLY(a_result_nonzero, clk, arst_n, $rose(res.valid), res.events_in_window != '0)

endmodule

### tb/sliding_window_event_rate_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_event_rate_tb
// Self-checking bench for the sliding window event counter. A directed table
// exercises first-event, backwards time, zero and oversized windows and the
// field extremes. Random phases then sweep several window lengths, including
// one wide enough to build up several hundred ring entries, under random
// stalls on both channels but in the last phase. Every result word is
// compared with a hand-worked table answer or an in-bench window predictor.
// ----------------------------------------------------------------------------
module sliding_window_event_rate_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH   = swer_pkg::DEPTH_DEFAULT;
	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_OFF     = 300;
	localparam int PRESSURE_AT  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX   = 10;

	typedef logic [swer_pkg::TIME_W-1:0]      stamp_t;
	typedef logic [swer_pkg::COUNT_OUT_W-1:0] count_t;

	typedef struct packed {
		stamp_t delta;
		count_t count;
	} result_t;

	typedef enum logic {ROW_EVENT, ROW_WINDOW} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		stamp_t    value;
		logic      typed;
		result_t   want;
	} dir_row_t;

	localparam stamp_t STAMP_MAX = '1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	stamp_t cfg_data;

	swer_evt_if evt_ch();
	swer_res_if res_ch();

	sliding_window_event_rate #(.DEPTH(RING_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.evt      (evt_ch),
		.res      (res_ch)
	);

	// Window state mirrored from the block
	stamp_t stamp_mem [RING_DEPTH];
	int     oldest_idx = 0;
	int     write_idx  = 0;
	int     stored     = 0;
	stamp_t last_stamp = '0;
	logic   any_seen   = 1'b0;
	stamp_t window_len = swer_pkg::WINDOW_RESET;

	result_t awaited_results[$];
	int unsigned mismatches    = 0;
	int unsigned results_taken = 0;
	int unsigned quiet_cycles  = 0;
	logic calm       = 1'b0;
	logic tx_idle_on = 1'b1;
	logic rx_idle_on = 1'b1;

	// Directed table: window writes and event words, most with hand-worked answers
	dir_row_t script [19] = '{
		'{ROW_EVENT,  48'd0,              1'b1, '{48'd0, 11'd1}},
		'{ROW_EVENT,  48'd0,              1'b1, '{48'd0, 11'd2}},
		'{ROW_EVENT,  48'd5,              1'b1, '{48'd5, 11'd3}},
		'{ROW_EVENT,  48'd3,              1'b1, '{48'd0, 11'd4}},
		'{ROW_WINDOW, 48'd0,              1'b0, '{48'd0, 11'd0}},
		'{ROW_EVENT,  48'd3,              1'b1, '{48'd0, 11'd3}},
		'{ROW_EVENT,  48'd10,             1'b1, '{48'd7, 11'd1}},
		'{ROW_EVENT,  48'd10,             1'b1, '{48'd0, 11'd2}},
		'{ROW_WINDOW, 48'hFFFF_FFFF_FFFF, 1'b0, '{48'd0, 11'd0}},
		'{ROW_EVENT,  48'hFFFF_FFFF_FFFE, 1'b1, '{48'hFFFF_FFFF_FFF4, 11'd3}},
		'{ROW_EVENT,  48'hFFFF_FFFF_FFFF, 1'b1, '{48'd1, 11'd4}},
		'{ROW_EVENT,  48'd0,              1'b1, '{48'd0, 11'd5}},
		'{ROW_WINDOW, 48'd1,              1'b0, '{48'd0, 11'd0}},
		'{ROW_EVENT,  48'hFFFF_FFFF_FFFF, 1'b1, '{48'hFFFF_FFFF_FFFF, 11'd4}},
		'{ROW_EVENT,  48'h5555_5555_5555, 1'b1, '{48'd0, 11'd5}},
		'{ROW_WINDOW, 48'd100,            1'b0, '{48'd0, 11'd0}},
		'{ROW_EVENT,  48'hAAAA_AAAA_AAAA, 1'b0, '{48'd0, 11'd0}},
		'{ROW_EVENT,  48'hAAAA_AAAA_AAAA, 1'b0, '{48'd0, 11'd0}},
		'{ROW_EVENT,  48'hAAAA_AAAA_AB10, 1'b0, '{48'd0, 11'd0}}
	};

	function automatic int ring_next(int idx);
		return (idx + 1 >= RING_DEPTH) ? 0 : idx + 1;
	endfunction

	// Push one timestamp, expire old ones, and return the result word
	function automatic result_t window_step(stamp_t now);
		result_t r;
		stamp_t cutoff;
		r.delta = (any_seen && now >= last_stamp) ? now - last_stamp : '0;
		if (stored >= RING_DEPTH) begin
			oldest_idx = ring_next(oldest_idx);
			stored--;
		end
		stamp_mem[write_idx] = now;
		write_idx = ring_next(write_idx);
		stored++;
		if (now >= window_len) begin
			cutoff = now - window_len;
			while (stored > 1 && stamp_mem[oldest_idx] < cutoff) begin
				oldest_idx = ring_next(oldest_idx);
				stored--;
			end
		end
		last_stamp = now;
		any_seen = 1'b1;
		r.count = (stored > int'(swer_pkg::COUNT_MAX)) ? swer_pkg::COUNT_MAX : count_t'(stored);
		return r;
	endfunction

	function automatic stamp_t rand_stamp();
		return stamp_t'({$urandom, $urandom});
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one event word, wait for it to be taken, record its expectation
	task automatic send_event(stamp_t stamp, logic typed, result_t want);
		result_t got;
		if (!calm && tx_idle_on && $urandom_range(0, 3) == 0) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.event_time <= stamp;
		do @(posedge clk); while (!evt_ch.ready);
		got = window_step(stamp);
		awaited_results.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	// Write the window length once the block has drained
	task automatic set_window(stamp_t len);
		evt_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		window_len = len;
	endtask

	// Mostly rising timestamps with random steps, plus some noise words
	task automatic run_phase(stamp_t len, int items, int unsigned scale, stamp_t start);
		stamp_t cur;
		stamp_t stamp;
		logic [swer_pkg::TIME_W:0] wide;
		int unsigned pick;
		int unsigned step;
		set_window(len);
		cur = start;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			step = $urandom_range(scale, 0);
			if (pick < 4) begin
				stamp = (cur > stamp_t'(step)) ? cur - stamp_t'(step) : '0;
			end else if (pick < 7) begin
				stamp = rand_stamp();
			end else if (pick < 20) begin
				stamp = cur;
			end else begin
				wide = {1'b0, cur} + (swer_pkg::TIME_W+1)'(step);
				stamp = wide[swer_pkg::TIME_W] ? STAMP_MAX : wide[swer_pkg::TIME_W-1:0];
			end
			cur = stamp;
			if ($urandom_range(0, 29) == 0) tx_idle_on = !tx_idle_on;
			send_event(stamp, 1'b0, '0);
		end
	endtask

	// Stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		evt_ch.valid = 1'b0;
		evt_ch.event_time = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WINDOW) begin
				set_window(script[i].value);
			end else begin
				send_event(script[i].value, script[i].typed, script[i].want);
			end
		end

		run_phase(48'd1000, 100, 400, last_stamp);
		run_phase(48'd0, 30, 3, last_stamp);
		run_phase(48'd1, 30, 3, last_stamp);
		run_phase(rand_stamp(), 30, $urandom, last_stamp);
		// build up a deep ring: nothing expires under the widest window
		run_phase(STAMP_MAX, 600, 1000, 48'd0);
		// a narrow window then drains most of the deep ring at once
		run_phase(48'd50000, 60, 2000, last_stamp);
		calm = 1'b1;
		run_phase(swer_pkg::WINDOW_RESET, 40, 40000000, last_stamp);

		evt_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("sliding_window_event_rate_tb passed");
		end else begin
			$display("sliding_window_event_rate_tb failed");
		end
		$finish;
	end

	// Result side: random stall bursts and one long hold-off
	initial begin
		int stall_left;
		logic pressure_done;
		stall_left = 0;
		pressure_done = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 59) == 0) rx_idle_on = !rx_idle_on;
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!calm && !pressure_done && results_taken >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				stall_left = HOLD_OFF - 1;
				res_ch.ready <= 1'b0;
			end else if (!calm && rx_idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_taken++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result word: delta %0d count %0d",
						res_ch.delta_time, res_ch.events_in_window);
			end else begin
				want = awaited_results.pop_front();
				if (res_ch.delta_time !== want.delta) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result %0d delta_time: expected %0d, got %0d",
							results_taken, want.delta, res_ch.delta_time);
				end
				if (res_ch.events_in_window !== want.count) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result %0d events_in_window: expected %0d, got %0d",
							results_taken, want.count, res_ch.events_in_window);
				end
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("sliding_window_event_rate_tb failed");
				$finish;
			end
		end
	end

endmodule
